[rtl/core/btcio_pkg.sv]
// Package for the block transfer / compare / port I/O step unit.
// Holds the command and result beat structs, operation codes and flag positions.
// No dependencies.
`default_nettype none

package btcio_pkg;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_CMP      = 2'd1,
    OP_PORT_IN  = 2'd2,
    OP_PORT_OUT = 2'd3
  } op_t;

  localparam logic [1:0] WT_NONE = 2'd0;
  localparam logic [1:0] WT_MEM  = 2'd1;
  localparam logic [1:0] WT_PORT = 2'd2;

  // kind field layout
  localparam int KIND_DEC_BIT = 2;
  localparam int KIND_REP_BIT = 3;

  // flag register bit positions
  localparam int FLAG_S = 7;
  localparam int FLAG_Z = 6;
  localparam int FLAG_Y = 5;
  localparam int FLAG_H = 4;
  localparam int FLAG_X = 3;
  localparam int FLAG_P = 2;
  localparam int FLAG_N = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  reg_a;
    logic [7:0]  reg_f;
    logic [15:0] reg_bc;
    logic [15:0] reg_de;
    logic [15:0] reg_hl;
    logic [15:0] reg_wz;
    logic [15:0] reg_pc;
    logic [7:0]  data_in;
  } btcio_in_t;

  typedef struct packed {
    logic [7:0]  new_f;
    logic [15:0] new_bc;
    logic [15:0] new_de;
    logic [15:0] new_hl;
    logic [15:0] new_wz;
    logic [15:0] new_pc;
    logic [1:0]  write_target;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        repeat_res;
  } btcio_out_t;

endpackage

`default_nettype wire

[rtl/core/btcio_exec.sv]
// Combinational datapath for one block instruction step: flags, pair updates,
// write request and repeat decision. Depends on btcio_pkg.
`default_nettype none

module btcio_exec (
  input  btcio_pkg::btcio_in_t  cmd,
  output btcio_pkg::btcio_out_t res
);
  import btcio_pkg::*;

  op_t         op;
  logic        dec;
  logic        rep;
  logic [15:0] step;
  logic [15:0] bc_m1;
  logic [15:0] pc_m2;
  logic [15:0] pc_m1;
  logic [15:0] hl_step;
  logic [15:0] de_step;
  logic [15:0] wz_step;
  logic        bc_nz;

  logic [7:0]  ld_sum;
  logic [7:0]  cp_diff;
  logic [7:0]  cp_adj;
  logic        cp_half;
  logic        cp_zero;

  logic [7:0]  io_b;
  logic [7:0]  io_c;
  logic [15:0] io_bc;
  logic [15:0] io_bc_step;
  logic [7:0]  io_addend;
  logic [8:0]  io_sum;
  logic        io_par;
  logic        io_again;
  logic [7:0]  io_f;

  assign op      = op_t'(cmd.kind[1:0]);
  assign dec     = cmd.kind[KIND_DEC_BIT];
  assign rep     = cmd.kind[KIND_REP_BIT];
  assign step    = dec ? 16'hFFFF : 16'h0001;
  assign bc_m1   = cmd.reg_bc - 16'd1;
  assign bc_nz   = (bc_m1 != 16'd0);
  assign pc_m2   = cmd.reg_pc - 16'd2;
  assign pc_m1   = cmd.reg_pc - 16'd1;
  assign hl_step = cmd.reg_hl + step;
  assign de_step = cmd.reg_de + step;
  assign wz_step = cmd.reg_wz + step;

  assign ld_sum  = cmd.data_in + cmd.reg_a;

  // undocumented y/x come from the difference less the half borrow
  assign cp_diff = cmd.reg_a - cmd.data_in;
  assign cp_half = (cp_diff[3:0] > cmd.reg_a[3:0]);
  assign cp_adj  = cp_half ? (cp_diff - 8'd1) : cp_diff;
  assign cp_zero = (cp_diff == 8'd0);

  assign io_b       = cmd.reg_bc[15:8] - 8'd1;
  assign io_c       = cmd.reg_bc[7:0];
  assign io_bc      = {io_b, io_c};
  assign io_bc_step = ((op == OP_PORT_IN) ? cmd.reg_bc : io_bc) + step;
  // input adds C+/-1, output adds the low byte of the stepped HL
  assign io_addend  = (op == OP_PORT_IN) ? (io_c + step[7:0]) : hl_step[7:0];
  assign io_sum     = {1'b0, io_addend} + {1'b0, cmd.data_in};
  assign io_par     = ~^({5'd0, io_sum[2:0]} ^ io_b);
  assign io_again   = rep && (io_b != 8'd0);

  always_comb begin
    io_f         = '0;
    io_f[FLAG_S] = io_b[7];
    io_f[FLAG_Z] = (io_b == 8'd0);
    io_f[FLAG_H] = io_sum[8];
    io_f[FLAG_P] = io_par;
    io_f[FLAG_N] = cmd.data_in[7];
    io_f[FLAG_C] = io_sum[8];
  end

  always_comb begin
    res              = '0;
    res.new_bc       = cmd.reg_bc;
    res.new_de       = cmd.reg_de;
    res.new_hl       = cmd.reg_hl;
    res.new_wz       = cmd.reg_wz;
    res.new_pc       = cmd.reg_pc;
    res.write_target = WT_NONE;
    unique case (op)
      OP_LOAD: begin
        res.new_f[FLAG_S] = cmd.reg_f[FLAG_S];
        res.new_f[FLAG_Z] = cmd.reg_f[FLAG_Z];
        res.new_f[FLAG_Y] = ld_sum[1];
        res.new_f[FLAG_X] = ld_sum[3];
        res.new_f[FLAG_P] = bc_nz;
        res.new_f[FLAG_C] = cmd.reg_f[FLAG_C];
        res.new_bc        = bc_m1;
        res.new_de        = de_step;
        res.new_hl        = hl_step;
        res.write_target  = WT_MEM;
        res.write_addr    = cmd.reg_de;
        res.write_data    = cmd.data_in;
        res.repeat_res    = rep && bc_nz;
        if (rep && bc_nz) begin
          res.new_pc = pc_m2;
          res.new_wz = pc_m1;
        end
      end
      OP_CMP: begin
        res.new_f[FLAG_S] = cp_diff[7];
        res.new_f[FLAG_Z] = cp_zero;
        res.new_f[FLAG_Y] = cp_adj[1];
        res.new_f[FLAG_H] = cp_half;
        res.new_f[FLAG_X] = cp_adj[3];
        res.new_f[FLAG_P] = bc_nz;
        res.new_f[FLAG_N] = 1'b1;
        res.new_f[FLAG_C] = cmd.reg_f[FLAG_C];
        res.new_bc        = bc_m1;
        res.new_hl        = hl_step;
        res.new_wz        = wz_step;
        res.repeat_res    = rep && bc_nz && !cp_zero;
        if (rep && bc_nz && !cp_zero) begin
          res.new_pc = pc_m2;
          res.new_wz = pc_m1;
        end
      end
      OP_PORT_IN: begin
        res.new_f        = io_f;
        res.new_bc       = io_bc;
        res.new_hl       = hl_step;
        res.new_wz       = io_bc_step;
        res.write_target = WT_MEM;
        res.write_addr   = cmd.reg_hl;
        res.write_data   = cmd.data_in;
        res.repeat_res   = io_again;
        if (io_again) begin
          res.new_pc = pc_m2;
        end
      end
      OP_PORT_OUT: begin
        res.new_f        = io_f;
        res.new_bc       = io_bc;
        res.new_hl       = hl_step;
        res.new_wz       = io_bc_step;
        res.write_target = WT_PORT;
        res.write_addr   = io_bc;
        res.write_data   = cmd.data_in;
        res.repeat_res   = io_again;
        if (io_again) begin
          res.new_pc = pc_m2;
        end
      end
      default: begin
        res.new_f = cmd.reg_f;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/block_transfer_compare_io_step.sv]
// Top level of the block transfer / compare / port I/O step unit.
// Instantiates btcio_exec between a command register and a result register.
// Depends on btcio_pkg.
//
// Usage:
//   Command channel: drive cmd and raise start; a beat is taken at each rising
//   edge with start high and busy low. busy stays low, so a new command may be
//   issued in every cycle.
//   Result channel: done is high for exactly one cycle with the result beat on
//   result; the receiver must take it then, it cannot stall the unit.
//   A taken command is registered in the command register, evaluated in one pass of
//   the step logic, and its result is registered in the result register with done.
//   Throughput: one command per cycle, set by the single registered pass of the
//   step datapath between the command and result registers.
//   Reset (synchronous, active high) drops any command in flight; no result
//   beat is produced for it and done is low after reset.
`default_nettype none

module block_transfer_compare_io_step (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  btcio_pkg::btcio_in_t  cmd,
  output logic                  done,
  output btcio_pkg::btcio_out_t result
);
  import btcio_pkg::*;

  btcio_in_t  cmd_q;
  logic       cmd_vld;
  btcio_out_t exec_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      cmd_vld <= start;
      done    <= cmd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd;
    end
    if (cmd_vld) begin
      result <= exec_res;
    end
  end

  btcio_exec u_exec (
    .cmd (cmd_q),
    .res (exec_res)
  );

endmodule

`default_nettype wire

[dv/tb_block_transfer_compare_io_step.sv]
// Self-checking testbench for block_transfer_compare_io_step: directed and random block
// instruction steps, each result compared field by field with a local model of the step.
// Depends on btcio_pkg and the block_transfer_compare_io_step RTL.
module tb_block_transfer_compare_io_step;
  import btcio_pkg::*;

  localparam int STALL_LIMIT = 500;
  localparam int RANDOM_CMDS = 550;

  typedef struct {
    btcio_in_t beat;
    bit        drain;   // hold this beat until every earlier result is back
  } pending_cmd_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  btcio_in_t  cmd = '0;
  logic       busy;
  logic       done;
  btcio_out_t result;

  pending_cmd_t cmd_queue[$];
  btcio_out_t   expected_steps[$];
  int           cmds_issued = 0;
  int           cmds_taken = 0;
  int           results_seen = 0;
  int           repeats_seen = 0;
  int           mismatches = 0;
  int           stall_cycles = 0;
  logic [15:0]  kinds_hit = '0;

  block_transfer_compare_io_step u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // flags of the port in / port out forms
  function automatic logic [7:0] io_step_flags(logic [7:0] b, logic [7:0] val,
                                               logic [7:0] addend);
    logic [8:0] sum;
    logic [7:0] f;
    logic [7:0] pmix;
    sum = {1'b0, addend} + {1'b0, val};
    f = '0;
    if (b == 8'd0) f[FLAG_Z] = 1'b1;
    else f[FLAG_S] = b[7];
    f[FLAG_N] = val[7];
    f[FLAG_H] = sum[8];
    f[FLAG_C] = sum[8];
    pmix = {5'd0, sum[2:0]} ^ b;
    f[FLAG_P] = ~^pmix;
    return f;
  endfunction

  function automatic btcio_out_t predict_block_step(btcio_in_t c);
    btcio_out_t  r;
    logic [15:0] inc;
    logic [7:0]  v;
    logic [7:0]  diff;
    logic [7:0]  b;
    logic [7:0]  cl;
    logic        rep;
    logic        again;
    r = '0;
    r.new_bc = c.reg_bc;
    r.new_de = c.reg_de;
    r.new_hl = c.reg_hl;
    r.new_wz = c.reg_wz;
    r.new_pc = c.reg_pc;
    r.write_target = WT_NONE;
    inc = c.kind[KIND_DEC_BIT] ? 16'hFFFF : 16'h0001;
    rep = c.kind[KIND_REP_BIT];
    cl = c.reg_bc[7:0];
    b = c.reg_bc[15:8] - 8'd1;
    again = 1'b0;
    case (op_t'(c.kind[1:0]))
      OP_LOAD: begin
        v = c.data_in + c.reg_a;
        r.new_f[FLAG_S] = c.reg_f[FLAG_S];
        r.new_f[FLAG_Z] = c.reg_f[FLAG_Z];
        r.new_f[FLAG_C] = c.reg_f[FLAG_C];
        r.new_f[FLAG_Y] = v[1];
        r.new_f[FLAG_X] = v[3];
        r.write_target = WT_MEM;
        r.write_addr = c.reg_de;
        r.write_data = c.data_in;
        r.new_hl = c.reg_hl + inc;
        r.new_de = c.reg_de + inc;
        r.new_bc = c.reg_bc - 16'd1;
        r.new_f[FLAG_P] = (r.new_bc != 16'd0);
        again = rep && (r.new_bc != 16'd0);
        if (again) begin
          r.new_pc = c.reg_pc - 16'd2;
          r.new_wz = r.new_pc + 16'd1;
        end
      end
      OP_CMP: begin
        diff = c.reg_a - c.data_in;
        r.new_f[FLAG_N] = 1'b1;
        r.new_f[FLAG_C] = c.reg_f[FLAG_C];
        if (diff == 8'd0) r.new_f[FLAG_Z] = 1'b1;
        else r.new_f[FLAG_S] = diff[7];
        // half borrow: y/x then come from the difference less one
        if (diff[3:0] > c.reg_a[3:0]) begin
          r.new_f[FLAG_H] = 1'b1;
          diff = diff - 8'd1;
        end
        r.new_f[FLAG_Y] = diff[1];
        r.new_f[FLAG_X] = diff[3];
        r.new_wz = c.reg_wz + inc;
        r.new_hl = c.reg_hl + inc;
        r.new_bc = c.reg_bc - 16'd1;
        r.new_f[FLAG_P] = (r.new_bc != 16'd0);
        again = rep && (r.new_bc != 16'd0) && !r.new_f[FLAG_Z];
        if (again) begin
          r.new_pc = c.reg_pc - 16'd2;
          r.new_wz = r.new_pc + 16'd1;
        end
      end
      OP_PORT_IN: begin
        r.new_wz = c.reg_bc + inc;
        r.new_bc = {b, cl};
        r.write_target = WT_MEM;
        r.write_addr = c.reg_hl;
        r.write_data = c.data_in;
        r.new_hl = c.reg_hl + inc;
        r.new_f = io_step_flags(b, c.data_in, cl + inc[7:0]);
        again = rep && (b != 8'd0);
        if (again) r.new_pc = c.reg_pc - 16'd2;
      end
      default: begin
        r.new_hl = c.reg_hl + inc;
        r.new_bc = {b, cl};
        r.new_wz = r.new_bc + inc;
        r.write_target = WT_PORT;
        r.write_addr = r.new_bc;
        r.write_data = c.data_in;
        r.new_f = io_step_flags(b, c.data_in, r.new_hl[7:0]);
        again = rep && (b != 8'd0);
        if (again) r.new_pc = c.reg_pc - 16'd2;
      end
    endcase
    r.repeat_res = again;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic queue_cmd(logic [3:0] kind, logic [7:0] a, logic [7:0] f,
                           logic [15:0] bc, logic [15:0] de, logic [15:0] hl,
                           logic [15:0] wz, logic [15:0] pc, logic [7:0] d,
                           bit drain);
    pending_cmd_t p;
    p.beat = '{kind: kind, reg_a: a, reg_f: f, reg_bc: bc, reg_de: de, reg_hl: hl,
               reg_wz: wz, reg_pc: pc, data_in: d};
    p.drain = drain;
    cmd_queue.push_back(p);
  endtask

  // addresses and counters leaning toward the wrap points
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 2));
      3: return 16'($urandom_range(16'hFFFD, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_counter();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 2));
      1: return {8'($urandom_range(0, 2)), 8'($urandom)};
      2: return {8'($urandom), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      default: return 16'($urandom);
    endcase
  endfunction

  // driver: next beat goes up once the current one is taken
  always @(posedge clk) begin : drive_cmd
    pending_cmd_t nxt;
    bit           quiet;
    bit           hold;
    if (rst) begin
      start <= 1'b0;
      cmd <= '0;
    end else if (!start || !busy) begin
      quiet = (cmds_issued >= 250) && (cmds_issued < 370);
      hold = !quiet && ($urandom_range(0, 99) < 9);
      if (cmd_queue.size() != 0 && cmd_queue[0].drain &&
          (start || expected_steps.size() != 0))
        hold = 1'b1;
      if (cmd_queue.size() != 0 && !hold) begin
        nxt = cmd_queue.pop_front();
        cmd <= nxt.beat;
        start <= 1'b1;
        cmds_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the result beat, then record the command beat taken at this edge
  always @(posedge clk) begin : check_results
    btcio_out_t want;
    if (!rst) begin
      if (done) begin
        results_seen++;
        if (expected_steps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got %h", $time, result);
        end else begin
          want = expected_steps.pop_front();
          if (want.repeat_res) repeats_seen++;
          check_field("new_f", 16'(want.new_f), 16'(result.new_f));
          check_field("new_bc", want.new_bc, result.new_bc);
          check_field("new_de", want.new_de, result.new_de);
          check_field("new_hl", want.new_hl, result.new_hl);
          check_field("new_wz", want.new_wz, result.new_wz);
          check_field("new_pc", want.new_pc, result.new_pc);
          check_field("write_target", 16'(want.write_target), 16'(result.write_target));
          check_field("write_addr", want.write_addr, result.write_addr);
          check_field("write_data", 16'(want.write_data), 16'(result.write_data));
          check_field("repeat_res", 16'(want.repeat_res), 16'(result.repeat_res));
        end
      end
      if (start && !busy) begin
        expected_steps.push_back(predict_block_step(cmd));
        kinds_hit[cmd.kind] = 1'b1;
        cmds_taken++;
      end
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin : run
    logic [3:0]  kind;
    logic [7:0]  a;
    logic [7:0]  d;
    logic [15:0] bc;
    // load: counter reaching zero, counter wrapping, pointer wrap
    queue_cmd(4'h0, 8'h00, 8'hFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h1234, 16'h0000, 8'h00, 0);
    queue_cmd(4'hC, 8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 8'hFF, 0);
    queue_cmd(4'h8, 8'h0A, 8'h41, 16'h0001, 16'h8000, 16'h4000, 16'hBEEF, 16'h0100, 8'h02, 0);
    queue_cmd(4'h4, 8'h55, 8'hAA, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hAA, 0);
    // compare: match ends the repeat, half borrow, counter wrap, sign
    queue_cmd(4'h9, 8'h5A, 8'h00, 16'h0010, 16'h1111, 16'h2000, 16'h0000, 16'h0002, 8'h5A, 0);
    queue_cmd(4'h1, 8'h10, 8'hFF, 16'h0005, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 8'h01, 0);
    queue_cmd(4'hD, 8'h00, 8'h01, 16'h0000, 16'h2222, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 0);
    queue_cmd(4'h5, 8'h80, 8'h00, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 8'h00, 0);
    // port in: carry out of the C adjust, B wrapping, repeat and final pass
    queue_cmd(4'h2, 8'h00, 8'h00, 16'h01FF, 16'h3333, 16'hFFFF, 16'h0000, 16'h0000, 8'hFF, 0);
    queue_cmd(4'h6, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h80, 0);
    queue_cmd(4'hA, 8'h12, 8'h34, 16'h0280, 16'hAAAA, 16'h1234, 16'h0000, 16'h0001, 8'h7F, 0);
    queue_cmd(4'hE, 8'h00, 8'h00, 16'h0101, 16'h0000, 16'h0000, 16'h0000, 16'h0040, 8'h01, 0);
    // port out: wrap of HL and B, repeat and final pass
    queue_cmd(4'h3, 8'h00, 8'h00, 16'h0200, 16'h4444, 16'h00FF, 16'h0000, 16'h0000, 8'h01, 0);
    queue_cmd(4'h7, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF, 0);
    queue_cmd(4'hB, 8'h00, 8'h00, 16'h0033, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 8'h81, 0);
    queue_cmd(4'hF, 8'h00, 8'h00, 16'h01FF, 16'h0000, 16'h0080, 16'h0000, 16'h0000, 8'h7F, 0);
    // all-zero and all-one beats
    queue_cmd(4'h0, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 0);
    queue_cmd(4'hF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0);
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      kind = 4'($urandom);
      a = 8'($urandom);
      d = 8'($urandom);
      bc = pick_counter();
      // matching compares stop a repeating search early
      if (kind[1:0] == OP_CMP && $urandom_range(0, 3) == 0) d = a;
      queue_cmd(kind, a, 8'($urandom), bc, pick_word(), pick_word(), pick_word(),
                pick_word(), d, (i == 0) || (i == 300) || ($urandom_range(0, 99) == 0));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while ((cmd_queue.size() != 0 || start || expected_steps.size() != 0) &&
           stall_cycles < STALL_LIMIT)
      @(negedge clk);
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL block_transfer_compare_io_step");
    end else begin
      repeat (8) @(negedge clk);
      $display("checked %0d results for %0d commands, %0d of 16 kinds", results_seen,
               cmds_taken, $countones(kinds_hit));
      $display("%0d steps repeated, %0d mismatches", repeats_seen, mismatches);
      if (mismatches == 0 && expected_steps.size() == 0) begin
        $display("PASS block_transfer_compare_io_step");
      end else begin
        if (expected_steps.size() != 0)
          $display("%0d results never arrived", expected_steps.size());
        $display("FAIL block_transfer_compare_io_step");
      end
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/btcio_pkg.sv
rtl/core/btcio_exec.sv
rtl/core/block_transfer_compare_io_step.sv
dv/tb_block_transfer_compare_io_step.sv
